@@ hdl/kvt_pkg.sv @@
// Shared types, codes and the microprogram of the keyed record table.
package kvt_pkg;

  localparam int KEY_W   = 16;
  localparam int PAY_W   = 64;
  localparam int ENTRY_W = 5;
  localparam int STEP_W  = 4;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_GET    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_MODIFY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Microprogram addresses.
  typedef enum logic [STEP_W-1:0] {
    S_IDLE    = 4'd0,
    S_SCAN    = 4'd1,
    S_CMP     = 4'd2,
    S_NEXT    = 4'd3,
    S_DISP    = 4'd4,
    S_ADD_WR  = 4'd5,
    S_GET_RD  = 4'd6,
    S_GET_LD  = 4'd7,
    S_MOD_WR  = 4'd8,
    S_DEL_RD  = 4'd9,
    S_DEL_WR  = 4'd10,
    S_DEL_FIN = 4'd11,
    S_OUT     = 4'd12
  } step_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_IN_ACC    = 3'd1,
    C_SCAN_END  = 3'd2,
    C_MATCH     = 3'd3,
    C_SHIFT_END = 3'd4,
    C_OUT_TAKEN = 3'd5,
    C_DISPATCH  = 3'd6
  } cond_t;

  // Memory write source.
  typedef enum logic [1:0] {
    W_NONE  = 2'd0,
    W_ADD   = 2'd1,
    W_MOD   = 2'd2,
    W_SHIFT = 2'd3
  } wsrc_t;

  // Memory read address select.
  typedef enum logic {
    R_IDX  = 1'b0,
    R_IDX1 = 1'b1
  } rsel_t;

  typedef struct packed {
    logic  in_rdy;
    logic  out_vld;
    logic  hold;      // stay on this step when the condition is false
    cond_t cond;
    step_t target;
    logic  latch;     // capture request, clear index and flags
    logic  inc_idx;
    logic  mark;      // record a key match
    rsel_t rsel;
    wsrc_t wsrc;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  ld_rdpay;
  } ctrl_t;

  typedef struct packed {
    logic    in_acc;
    logic    out_taken;
    logic    scan_end;
    logic    key_match;
    logic    shift_end;
    logic    found;
    logic    full;
    action_t action;
  } flags_t;

  typedef struct packed {
    ctrl_t   ctrl;
    logic    fail;      // dispatch ends the request with an error status
    status_t fail_st;
  } seq_out_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w        = '0;
    w.cond   = C_ALWAYS;
    w.target = S_IDLE;
    w.rsel   = R_IDX;
    w.wsrc   = W_NONE;
    unique case (s)
      S_IDLE: begin
        w.in_rdy = 1'b1; w.hold = 1'b1; w.latch = 1'b1;
        w.cond = C_IN_ACC; w.target = S_SCAN;
      end
      S_SCAN: begin
        w.cond = C_SCAN_END; w.target = S_DISP;
      end
      S_CMP: begin
        w.mark = 1'b1; w.cond = C_MATCH; w.target = S_DISP;
      end
      S_NEXT: begin
        w.inc_idx = 1'b1; w.target = S_SCAN;
      end
      S_DISP: begin
        w.cond = C_DISPATCH; w.target = S_OUT;
      end
      S_ADD_WR: begin
        w.wsrc = W_ADD; w.cnt_inc = 1'b1; w.target = S_OUT;
      end
      S_GET_RD: begin
        w.target = S_GET_LD;
      end
      S_GET_LD: begin
        w.ld_rdpay = 1'b1; w.target = S_OUT;
      end
      S_MOD_WR: begin
        w.wsrc = W_MOD; w.target = S_OUT;
      end
      S_DEL_RD: begin
        w.rsel = R_IDX1; w.cond = C_SHIFT_END; w.target = S_DEL_FIN;
      end
      S_DEL_WR: begin
        w.wsrc = W_SHIFT; w.inc_idx = 1'b1; w.target = S_DEL_RD;
      end
      S_DEL_FIN: begin
        w.cnt_dec = 1'b1; w.target = S_OUT;
      end
      S_OUT: begin
        w.out_vld = 1'b1; w.hold = 1'b1;
        w.cond = C_OUT_TAKEN; w.target = S_IDLE;
      end
      default: begin
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hdl/kvt_if.sv @@
// Request and response channel interfaces of the keyed record table.
interface kvt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] key;
  logic [63:0] payload;

  modport source (output valid, action, key, payload, input ready);
  modport sink (input valid, action, key, payload, output ready);
endinterface

interface kvt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] read_payload;
  logic [4:0]  entry_total;

  modport source (output valid, status, read_payload, entry_total, input ready);
  modport sink (input valid, status, read_payload, entry_total, output ready);
endinterface

@@ hdl/kvt_sequencer.sv @@
// Step counter and control ROM that drive the table datapath.
module kvt_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  kvt_pkg::flags_t   flags,
  output kvt_pkg::seq_out_t sq
);
  import kvt_pkg::*;

  step_t pc;
  step_t pc_next;
  ctrl_t w;
  logic  take;
  step_t dest;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    w          = ucode(pc);
    dest       = w.target;
    sq.fail    = 1'b0;
    sq.fail_st = ST_DONE;
    unique case (w.cond)
      C_ALWAYS:    take = 1'b1;
      C_IN_ACC:    take = flags.in_acc;
      C_SCAN_END:  take = flags.scan_end;
      C_MATCH:     take = flags.key_match;
      C_SHIFT_END: take = flags.shift_end;
      C_OUT_TAKEN: take = flags.out_taken;
      C_DISPATCH: begin
        take = 1'b1;
        if (flags.action == ACT_ADD) begin
          if (flags.found) begin
            sq.fail = 1'b1; sq.fail_st = ST_DUPLICATE;
          end else if (flags.full) begin
            sq.fail = 1'b1; sq.fail_st = ST_FULL;
          end else begin
            dest = S_ADD_WR;
          end
        end else if (!flags.found) begin
          sq.fail = 1'b1; sq.fail_st = ST_NOT_FOUND;
        end else begin
          unique case (flags.action)
            ACT_GET:    dest = S_GET_RD;
            ACT_DELETE: dest = S_DEL_RD;
            default:    dest = S_MOD_WR;
          endcase
        end
      end
      default: take = 1'b0;
    endcase
    if (take) begin
      pc_next = dest;
    end else if (w.hold) begin
      pc_next = pc;
    end else begin
      pc_next = step_t'(pc + 1'b1);
    end
    sq.ctrl = w;
  end

endmodule

@@ hdl/keyed_record_table.sv @@
// Top level of the keyed record table: datapath, key and payload memories.
// Usage:
//   req (sink) carries one request beat: action (add/get/delete/modify),
//   16-bit key and 64-bit payload. rsp (source) returns one beat per
//   request: status, read_payload (get only, else zero) and entry_total.
//   A beat moves when valid and ready are both high at a rising edge.
// Timing:
//   One request at a time. The key search reads, compares and advances
//   over the live entries in turn; a lookup stops at the first matching
//   entry and a miss scans every live entry. A dispatch step follows; a
//   failed request goes straight to the response, else add writes the
//   new entry, modify writes the payload, get reads then loads, and delete
//   moves each later entry down (read, write), then decrements the count.
//   The response beat is offered the cycle after that; req.ready rises
//   again the cycle after it is taken. The worst case is set by the
//   three-step search loop on the single read port of the memories.
// Reset:
//   rst (synchronous) empties the table at once; no clearing pass, since
//   only live entries are ever read.
// Stall:
//   While rsp.ready is low the response beat holds and no request is taken.
module keyed_record_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  kvt_req_if.sink       req,
  kvt_rsp_if.source     rsp
);
  import kvt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Storage: packed entries 0 .. count-1 are live.
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [PAY_W-1:0] pay_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] key_rdata;
  logic [PAY_W-1:0] pay_rdata;

  // Request capture and working registers.
  action_t          action;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    count;
  logic             found;
  status_t          status;
  logic [PAY_W-1:0] rdpay;

  flags_t           flags;
  seq_out_t         sq;
  ctrl_t            c;

  logic [CW-1:0]    idx_inc;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [PAY_W-1:0] wr_pay;

  kvt_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .sq    (sq)
  );

  assign c       = sq.ctrl;
  assign idx_inc = idx + 1'b1;

  assign flags.in_acc    = req.valid & c.in_rdy;
  assign flags.out_taken = rsp.ready & c.out_vld;
  assign flags.scan_end  = (idx == count);
  assign flags.key_match = (key_rdata == key);
  assign flags.shift_end = (idx_inc == count);
  assign flags.found     = found;
  assign flags.full      = (count == CW'(TABLE_DEPTH));
  assign flags.action    = action;

  // Memory addressing: reads by search/shift index, add appends at count.
  assign rd_addr = (c.rsel == R_IDX1) ? idx_inc[IW-1:0] : idx[IW-1:0];
  assign wr_addr = (c.wsrc == W_ADD) ? count[IW-1:0] : idx[IW-1:0];
  assign wr_key  = (c.wsrc == W_SHIFT) ? key_rdata : key;
  assign wr_pay  = (c.wsrc == W_SHIFT) ? pay_rdata : payload;

  always_ff @(posedge clk) begin
    key_rdata <= key_mem[rd_addr];
    pay_rdata <= pay_mem[rd_addr];
    if (c.wsrc == W_ADD || c.wsrc == W_SHIFT) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (c.wsrc != W_NONE) begin
      pay_mem[wr_addr] <= wr_pay;
    end
  end

  // Request capture, index and result registers.
  always_ff @(posedge clk) begin
    if (c.latch && flags.in_acc) begin
      action  <= action_t'(req.action);
      key     <= req.key;
      payload <= req.payload;
      idx     <= '0;
      found   <= 1'b0;
      status  <= ST_DONE;
      rdpay   <= '0;
    end else begin
      if (c.inc_idx) begin
        idx <= idx_inc;
      end
      if (c.mark && flags.key_match) begin
        found <= 1'b1;
      end
      if (sq.fail) begin
        status <= sq.fail_st;
      end
      if (c.ld_rdpay) begin
        rdpay <= pay_rdata;
      end
    end
  end

  // Live entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (c.cnt_inc) begin
      count <= count + 1'b1;
    end else if (c.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  assign req.ready        = c.in_rdy;
  assign rsp.valid        = c.out_vld;
  assign rsp.status       = status;
  assign rsp.read_payload = rdpay;
  assign rsp.entry_total  = ENTRY_W'(count);

endmodule
